### rtl/cbst_pkg.sv
// Package for the conditional block skip tracker: command and warning codes,
// field widths, parameter defaults and the control word between step logic and top.
// No dependencies.
`timescale 1ns / 1ps

package cbst_pkg;

  localparam int CMD_W   = 3;
  localparam int WARN_W  = 3;
  localparam int DEPTH_W = 8;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int COUNT_MAX_DEF   = 255;

  typedef enum logic [CMD_W-1:0] {
    CMD_OTHER  = 3'd0,
    CMD_IF     = 3'd1,
    CMD_ELSEIF = 3'd2,
    CMD_ELSE   = 3'd3,
    CMD_ENDIF  = 3'd4,
    CMD_FSTART = 3'd5,
    CMD_FEND   = 3'd6,
    CMD_CSTART = 3'd7
  } cmd_t;

  typedef enum logic [WARN_W-1:0] {
    WARN_NONE        = 3'd0,
    WARN_ELSEIF_ORPH = 3'd1,
    WARN_ELSE_ORPH   = 3'd2,
    WARN_ENDIF_ORPH  = 3'd3,
    WARN_INCL_FALSE  = 3'd4,
    WARN_UNCLOSED    = 3'd5,
    WARN_STACK       = 3'd6
  } warn_t;

  // Stack control and warning produced by the step logic for one word.
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  sp_clear;
    warn_t warn;
  } ctl_t;

endpackage

### rtl/cbst_step.sv
// Combinational next-state logic of the conditional block skip tracker.
// Depends on cbst_pkg.
`timescale 1ns / 1ps

module cbst_step #(
  parameter int COUNT_MAX = cbst_pkg::COUNT_MAX_DEF,
  parameter int CNT_W     = $clog2(COUNT_MAX + 1)
) (
  input  logic [cbst_pkg::CMD_W-1:0] cmd,
  input  logic                       cond_true,
  input  logic                       eval_error,
  input  logic [CNT_W-1:0]           taken,
  input  logic [CNT_W-1:0]           skipped,
  input  logic                       else_pend,
  input  logic                       sp_empty,
  input  logic                       sp_full,
  input  logic [CNT_W-1:0]           top,
  output logic [CNT_W-1:0]           taken_nxt,
  output logic [CNT_W-1:0]           skipped_nxt,
  output logic                       else_pend_nxt,
  output cbst_pkg::ctl_t             ctl
);
  import cbst_pkg::*;

  localparam logic [CNT_W-1:0] CMAX = CNT_W'(COUNT_MAX);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v >= CMAX) ? CMAX : v + ONE;
  endfunction

  cmd_t cmd_e;
  logic sk_zero;
  logic tk_zero;

  assign cmd_e   = cmd_t'(cmd);
  assign sk_zero = (skipped == '0);
  assign tk_zero = (taken == '0);

  always_comb begin
    taken_nxt     = taken;
    skipped_nxt   = skipped;
    else_pend_nxt = else_pend;
    ctl           = '{push: 1'b0, pop: 1'b0, sp_clear: 1'b0, warn: WARN_NONE};
    unique case (cmd_e) inside
      CMD_IF: begin
        if (sk_zero && !eval_error) begin
          if (cond_true) begin
            taken_nxt = sat_inc(taken);
          end else begin
            skipped_nxt   = sat_inc(skipped);
            else_pend_nxt = 1'b1;
          end
        end else begin
          skipped_nxt = sat_inc(skipped);
        end
      end
      CMD_ELSEIF, CMD_ELSE: begin
        if (sk_zero) begin
          if (tk_zero) begin
            ctl.warn = (cmd_e == CMD_ELSEIF) ? WARN_ELSEIF_ORPH : WARN_ELSE_ORPH;
          end else begin
            // leave the taken branch: the rest of the block is skipped
            skipped_nxt = ONE;
            taken_nxt   = taken - ONE;
          end
        end else if (skipped == ONE && else_pend) begin
          if (cmd_e == CMD_ELSE || (cond_true && !eval_error)) begin
            skipped_nxt   = '0;
            taken_nxt     = sat_inc(taken);
            else_pend_nxt = 1'b0;
          end
        end
      end
      CMD_ENDIF: begin
        if (sk_zero) begin
          if (tk_zero) begin
            ctl.warn = WARN_ENDIF_ORPH;
          end else begin
            taken_nxt = taken - ONE;
          end
          else_pend_nxt = 1'b0;
        end else begin
          skipped_nxt = skipped - ONE;
          if (skipped == ONE) begin
            else_pend_nxt = 1'b0;
          end
        end
      end
      CMD_FSTART: begin
        if (!sk_zero) begin
          ctl.warn = WARN_INCL_FALSE;
        end
        if (sp_full) begin
          ctl.warn = WARN_STACK;
        end else begin
          ctl.push = 1'b1;
        end
        skipped_nxt   = '0;
        taken_nxt     = '0;
        else_pend_nxt = 1'b0;
      end
      CMD_FEND: begin
        if (!tk_zero || !sk_zero) begin
          ctl.warn = WARN_UNCLOSED;
        end
        skipped_nxt = '0;
        if (sp_empty) begin
          ctl.warn  = WARN_STACK;
          taken_nxt = '0;
        end else begin
          ctl.pop   = 1'b1;
          taken_nxt = top;
        end
      end
      CMD_CSTART: begin
        taken_nxt    = '0;
        skipped_nxt  = '0;
        ctl.sp_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/conditional_block_skip_tracker_top.sv
// Top level of the conditional block skip tracker: state registers, saved-depth
// stack and output register. Depends on cbst_pkg and cbst_step.
`timescale 1ns / 1ps

// Takes one command word per cycle while in_ready is high and returns one
// result word for each, registered in the cycle after acceptance; the output
// register lets a new word in only while it is empty or its result is taken in
// the same cycle, so throughput is one word per clock as long as the consumer
// keeps up. The whole update of both depth counters, the else-pending flag and
// the stack pointer is registered together on acceptance. The top of the saved
// stack is kept in a register and the entry below it is prefetched from the
// stack memory, so a file end restores the saved depth without waiting on the
// memory read. Stack contents are undefined until pushed; no clearing after reset.
module conditional_block_skip_tracker_top #(
  parameter int STACK_DEPTH = cbst_pkg::STACK_DEPTH_DEF,
  parameter int COUNT_MAX   = cbst_pkg::COUNT_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cbst_pkg::CMD_W-1:0]    in_cmd,
  input  logic                          in_cond_true,
  input  logic                          in_eval_error,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_skip_line,
  output logic [cbst_pkg::WARN_W-1:0]   out_warning,
  output logic [cbst_pkg::DEPTH_W-1:0]  out_true_depth,
  output logic [cbst_pkg::DEPTH_W-1:0]  out_false_depth
);
  import cbst_pkg::*;

  localparam int CNT_W  = $clog2(COUNT_MAX + 1);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SP_W-1:0] SP_ONE   = SP_W'(1);
  localparam logic [SP_W-1:0] SP_THREE = SP_W'(3);

  logic [CNT_W-1:0] taken_r, taken_nxt;
  logic [CNT_W-1:0] skipped_r, skipped_nxt;
  logic             else_pend_r, else_pend_nxt;
  logic [SP_W-1:0]  sp_r;
  logic [CNT_W-1:0] top_r;
  logic [CNT_W-1:0] second_r;
  logic [CNT_W-1:0] stack_mem [STACK_DEPTH];

  logic             accept;
  logic             sp_empty;
  logic             sp_full;
  logic [SP_W-1:0]  sp_m1;
  logic [SP_W-1:0]  sp_m3;
  ctl_t             ctl;

  logic                 out_valid_r;
  logic                 skip_r;
  warn_t                warn_r;
  logic [CNT_W-1:0]     tdep_r;
  logic [CNT_W-1:0]     fdep_r;
  logic [CNT_W+7:0]     tdep_ext;
  logic [CNT_W+7:0]     fdep_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign sp_empty = (sp_r == '0);
  assign sp_full  = (sp_r == SP_W'(STACK_DEPTH));
  assign sp_m1    = sp_r - SP_ONE;
  assign sp_m3    = sp_r - SP_THREE;

  cbst_step #(
    .COUNT_MAX (COUNT_MAX),
    .CNT_W     (CNT_W)
  ) u_step (
    .cmd           (in_cmd),
    .cond_true     (in_cond_true),
    .eval_error    (in_eval_error),
    .taken         (taken_r),
    .skipped       (skipped_r),
    .else_pend     (else_pend_r),
    .sp_empty      (sp_empty),
    .sp_full       (sp_full),
    .top           (top_r),
    .taken_nxt     (taken_nxt),
    .skipped_nxt   (skipped_nxt),
    .else_pend_nxt (else_pend_nxt),
    .ctl           (ctl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r     <= '0;
      skipped_r   <= '0;
      else_pend_r <= 1'b0;
      sp_r        <= '0;
    end else if (accept) begin
      taken_r     <= taken_nxt;
      skipped_r   <= skipped_nxt;
      else_pend_r <= else_pend_nxt;
      if (ctl.sp_clear) begin
        sp_r <= '0;
      end else if (ctl.push) begin
        sp_r <= sp_r + SP_ONE;
      end else if (ctl.pop) begin
        sp_r <= sp_m1;
      end
    end
  end

  // Top entry lives in top_r; memory holds the entries below it.
  always_ff @(posedge clk) begin
    if (accept && ctl.push) begin
      top_r    <= taken_r;
      second_r <= top_r;
      if (!sp_empty) begin
        stack_mem[sp_m1[ADDR_W-1:0]] <= top_r;
      end
    end else if (accept && ctl.pop) begin
      top_r    <= second_r;
      second_r <= stack_mem[sp_m3[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      skip_r <= (skipped_nxt != '0);
      warn_r <= ctl.warn;
      tdep_r <= taken_nxt;
      fdep_r <= skipped_nxt;
    end
  end

  // report the low byte of each counter
  assign tdep_ext = {8'b0, tdep_r};
  assign fdep_ext = {8'b0, fdep_r};

  assign out_valid       = out_valid_r;
  assign out_skip_line   = skip_r;
  assign out_warning     = warn_r;
  assign out_true_depth  = tdep_ext[DEPTH_W-1:0];
  assign out_false_depth = fdep_ext[DEPTH_W-1:0];

endmodule

### test/tb.sv
// Testbench for conditional_block_skip_tracker_top: directed, saturation, stack-limit
// and random runs with a line-by-line prediction of skip flag, warning and depths.
// Depends on cbst_pkg and the tracker RTL.
`timescale 1ns / 1ps

module tb;
  import cbst_pkg::*;

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int COUNT_MAX   = COUNT_MAX_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_WORDS_PER_PHASE = 40;

  typedef struct packed {
    logic               skip;
    warn_t              warn;
    logic [DEPTH_W-1:0] taken;
    logic [DEPTH_W-1:0] skipped;
  } line_result_t;

  class skip_tracker_board;
    int unsigned taken_cnt;
    int unsigned skipped_cnt;
    int unsigned sp;
    bit else_open;
    bit [DEPTH_W-1:0] saved_depth [STACK_DEPTH];
    line_result_t expected_lines [$];
    int mismatches;
    int checked;

    function new();
      taken_cnt = 0;
      skipped_cnt = 0;
      sp = 0;
      else_open = 1'b0;
      mismatches = 0;
      checked = 0;
      foreach (saved_depth[i]) saved_depth[i] = '0;
    endfunction

    function int unsigned bump(int unsigned v);
      return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
    endfunction

    function line_result_t predict_line(cmd_t c, bit ct, bit ee);
      line_result_t r;
      warn_t w;
      w = WARN_NONE;
      case (c)
        CMD_IF: begin
          if (skipped_cnt == 0 && !ee) begin
            if (ct) begin
              taken_cnt = bump(taken_cnt);
            end else begin
              skipped_cnt = bump(skipped_cnt);
              else_open = 1'b1;
            end
          end else begin
            // evaluation error or already skipping: enter as skipped for good
            skipped_cnt = bump(skipped_cnt);
          end
        end
        CMD_ELSEIF, CMD_ELSE: begin
          if (skipped_cnt == 0) begin
            if (taken_cnt == 0) begin
              w = (c == CMD_ELSEIF) ? WARN_ELSEIF_ORPH : WARN_ELSE_ORPH;
            end else begin
              skipped_cnt = bump(skipped_cnt);
              taken_cnt--;
            end
          end else if (skipped_cnt == 1 && else_open) begin
            if (c == CMD_ELSE || (ct && !ee)) begin
              skipped_cnt = 0;
              taken_cnt = bump(taken_cnt);
              else_open = 1'b0;
            end
          end
        end
        CMD_ENDIF: begin
          if (skipped_cnt == 0) begin
            if (taken_cnt == 0) w = WARN_ENDIF_ORPH;
            else taken_cnt--;
          end else begin
            skipped_cnt--;
          end
          if (skipped_cnt == 0) else_open = 1'b0;
        end
        CMD_FSTART: begin
          if (skipped_cnt != 0) begin
            w = WARN_INCL_FALSE;
            skipped_cnt = 0;
          end
          if (sp < STACK_DEPTH) begin
            saved_depth[sp] = taken_cnt[DEPTH_W-1:0];
            sp++;
          end else begin
            w = WARN_STACK;
          end
          taken_cnt = 0;
          else_open = 1'b0;
        end
        CMD_FEND: begin
          if (taken_cnt != 0 || skipped_cnt != 0) begin
            w = WARN_UNCLOSED;
            skipped_cnt = 0;
          end
          if (sp > 0) begin
            sp--;
            taken_cnt = 32'(saved_depth[sp]);
          end else begin
            w = WARN_STACK;
            taken_cnt = 0;
          end
        end
        CMD_CSTART: begin
          taken_cnt = 0;
          skipped_cnt = 0;
          sp = 0;
        end
        default: ;
      endcase
      r.skip = (skipped_cnt != 0);
      r.warn = w;
      r.taken = taken_cnt[DEPTH_W-1:0];
      r.skipped = skipped_cnt[DEPTH_W-1:0];
      return r;
    endfunction

    function void note_word(cmd_t c, bit ct, bit ee);
      expected_lines.push_back(predict_line(c, ct, ee));
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 50) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic skip, logic [WARN_W-1:0] warn, logic [DEPTH_W-1:0] td,
                      logic [DEPTH_W-1:0] fd);
      line_result_t exp;
      if (expected_lines.size() == 0) begin
        report_mismatch($sformatf("unexpected word skip=%0b warn=%0d true=%0d false=%0d",
                                  skip, warn, td, fd));
        return;
      end
      exp = expected_lines.pop_front();
      checked++;
      if (skip !== exp.skip)
        report_mismatch($sformatf("word %0d skip_line %0b, want %0b", checked, skip, exp.skip));
      if (warn !== exp.warn)
        report_mismatch($sformatf("word %0d warning %0d, want %0d", checked, warn, exp.warn));
      if (td !== exp.taken)
        report_mismatch($sformatf("word %0d true_depth %0d, want %0d", checked, td, exp.taken));
      if (fd !== exp.skipped)
        report_mismatch($sformatf("word %0d false_depth %0d, want %0d",
                                  checked, fd, exp.skipped));
    endtask

    function int pending();
      return expected_lines.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd = CMD_OTHER;
  logic in_cond_true = 1'b0;
  logic in_eval_error = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_skip_line;
  logic [WARN_W-1:0] out_warning;
  logic [DEPTH_W-1:0] out_true_depth;
  logic [DEPTH_W-1:0] out_false_depth;

  int in_idle_pct = 26;
  int out_idle_pct = 64;
  int words_sent = 0;
  int cycles = 0;

  skip_tracker_board board = new();

  conditional_block_skip_tracker_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_cond_true    (in_cond_true),
    .in_eval_error   (in_eval_error),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_skip_line   (out_skip_line),
    .out_warning     (out_warning),
    .out_true_depth  (out_true_depth),
    .out_false_depth (out_false_depth)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Check results before noting the new word: a result never belongs to a word
  // accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_result(out_skip_line, out_warning, out_true_depth, out_false_depth);
      if (in_valid && in_ready)
        board.note_word(cmd_t'(in_cmd), in_cond_true, in_eval_error);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_word(cmd_t c, bit ct = 1'b0, bit ee = 1'b0);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_cond_true <= ct;
    in_eval_error <= ee;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Mostly balanced If/ElseIf/Else/EndIf nests with random conditions.
  task automatic emit_nest();
    int open_blocks;
    open_blocks = 0;
    repeat ($urandom_range(3, 16)) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          if (open_blocks < 5) begin
            send_word(CMD_IF, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
            open_blocks++;
          end else begin
            send_word(CMD_OTHER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
        2: begin
          if (open_blocks > 0)
            send_word(CMD_ELSEIF, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
          else
            send_word(CMD_OTHER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        3: begin
          if (open_blocks > 0) send_word(CMD_ELSE, 1'($urandom_range(0, 1)));
          else send_word(CMD_OTHER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        4: begin
          if (open_blocks > 0) begin
            send_word(CMD_ENDIF, 1'($urandom_range(0, 1)));
            open_blocks--;
          end else begin
            send_word(CMD_OTHER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
        default: send_word(CMD_OTHER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
    end
    repeat (open_blocks) send_word(CMD_ENDIF, 1'($urandom_range(0, 1)));
  endtask

  // Included files, sometimes deeper than the stack, sometimes left open.
  task automatic emit_file_nest();
    int k;
    k = $urandom_range(1, STACK_DEPTH + 2);
    repeat (k) begin
      if ($urandom_range(0, 3) == 0) send_word(CMD_IF, 1'($urandom_range(0, 1)));
      send_word(CMD_FSTART);
      if ($urandom_range(0, 1)) emit_nest();
    end
    repeat ($urandom_range(k, k + 2)) begin
      if ($urandom_range(0, 4) == 0) send_word(CMD_IF, 1'($urandom_range(0, 1)));
      send_word(CMD_FEND);
    end
  endtask

  initial begin
    int pick;
    int stop;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // orphans, underflow, taken and skipped branches, errors, include in false
    send_word(CMD_OTHER);
    send_word(CMD_ELSEIF, 1'b1);
    send_word(CMD_ELSE);
    send_word(CMD_ENDIF);
    send_word(CMD_FEND);
    send_word(CMD_IF, 1'b1);
    send_word(CMD_IF, 1'b0);
    send_word(CMD_ELSEIF, 1'b1, 1'b1);
    send_word(CMD_ELSEIF, 1'b0);
    send_word(CMD_ELSEIF, 1'b1);
    send_word(CMD_ELSE);
    send_word(CMD_FSTART);
    send_word(CMD_IF, 1'b1, 1'b1);
    send_word(CMD_ELSE);
    send_word(CMD_ELSEIF, 1'b1);
    send_word(CMD_FEND, 1'b1, 1'b1);
    send_word(CMD_ENDIF);
    send_word(CMD_ENDIF);
    send_word(CMD_IF, 1'b0, 1'b1);
    send_word(CMD_FSTART);
    send_word(CMD_IF, 1'b0);
    send_word(CMD_ELSE);
    send_word(CMD_CSTART, 1'b1, 1'b1);
    send_word(CMD_FEND);

    // drive both depths into saturation
    send_word(CMD_CSTART);
    repeat (COUNT_MAX + 1) send_word(CMD_IF, 1'b1);
    send_word(CMD_IF, 1'b0);
    repeat (COUNT_MAX) send_word(CMD_IF, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    send_word(CMD_ELSE);
    repeat (3) send_word(CMD_ENDIF);

    // overflow the saved-depth stack, then unwind past empty
    send_word(CMD_CSTART);
    repeat (STACK_DEPTH + 2) begin
      send_word(CMD_IF, 1'b1);
      send_word(CMD_FSTART);
    end
    send_word(CMD_IF, 1'b0);
    send_word(CMD_FSTART);
    repeat (STACK_DEPTH + 3) send_word(CMD_FEND);
    send_word(CMD_IF, 1'b1);
    send_word(CMD_FEND);
    send_word(CMD_CSTART);
    hold_until_drained();

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 64 : 0;
      out_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 26 : 0;
      stop = words_sent + RANDOM_WORDS_PER_PHASE;
      while (words_sent < stop) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          emit_nest();
        end else if (pick < 70) begin
          emit_file_nest();
        end else begin
          repeat ($urandom_range(1, 6))
            send_word(cmd_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 7) == 0);
        end
      end
      hold_until_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d command words and checked %0d result words, %0d mismatches.",
             words_sent, board.checked, board.mismatches);
    $display("Covered orphans, saturation, stack overflow and underflow, random nests.");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
